// ===== src/hnp_pkg.sv =====
// Shared widths, codes and word types of the heightfield normal packer.
`default_nettype none
package hnp_pkg;

  // Default scales and elevation width
  localparam int XY_FULL_SCALE_DEF = 1023;
  localparam int Z_FULL_SCALE_DEF  = 1023;
  localparam int ELEV_BITS_DEF     = 16;

  // Register word width and register indexes
  localparam int CFG_W = 32;
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] REG_DY_SCALE  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_DX_SCALE  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_CELL_AREA = 2'd2;
  localparam logic [CFG_W-1:0] SCALE_ONE = 32'h0001_0000;

  // Place codes
  localparam logic [1:0] PLACE_FIRST = 2'd0;
  localparam logic [1:0] PLACE_MID   = 2'd1;
  localparam logic [1:0] PLACE_LAST  = 2'd2;
  localparam logic [1:0] PLACE_ALT   = 2'd3;

  // Reduced vector and search widths
  localparam int RED_BITS = 20;
  localparam int K_W  = 10;
  localparam int S_W  = 2 * RED_BITS + 2;
  localparam int T_W  = RED_BITS + K_W;
  localparam int F_W  = 2 * T_W;
  localparam int P_W  = 2 * K_W + S_W;
  localparam int Q_W  = K_W + S_W;
  localparam int XY_W = K_W + 1;
  localparam int Z_W  = K_W;
  localparam int OUT_W = 2 * XY_W + Z_W;

  // Cycles from the start edge to the done sample edge
  localparam int LATENCY = 17;

  // One search lane: trial code, k^2*s, k*s and the target (fs*a)^2
  typedef struct packed {
    logic [K_W-1:0] k;
    logic [P_W-1:0] p;
    logic [Q_W-1:0] q;
    logic [F_W-1:0] f;
  } lane_t;

  // Word handed from cell to cell
  typedef struct packed {
    logic           vld;
    logic           zero;
    logic           nx;
    logic           ny;
    logic [S_W-1:0] s;
    lane_t          x;
    lane_t          y;
    lane_t          z;
  } cell_word_t;

endpackage
`default_nettype wire

// ===== src/hnp_front.sv =====
// Front pipeline: differences, scaling, reduction, squares and search targets.
`default_nettype none
module hnp_front #(
  parameter int XY_FULL_SCALE = 1023,
  parameter int Z_FULL_SCALE  = 1023,
  parameter int ELEV_BITS     = 16
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          take,
  input  wire  signed [ELEV_BITS-1:0]  elev_center,
  input  wire  signed [ELEV_BITS-1:0]  elev_left,
  input  wire  signed [ELEV_BITS-1:0]  elev_right,
  input  wire  signed [ELEV_BITS-1:0]  elev_up,
  input  wire  signed [ELEV_BITS-1:0]  elev_down,
  input  wire         [1:0]            row_place,
  input  wire         [1:0]            col_place,
  input  wire         [hnp_pkg::CFG_W-1:0] dy_scale,
  input  wire         [hnp_pkg::CFG_W-1:0] dx_scale,
  input  wire         [hnp_pkg::CFG_W-1:0] cell_area,
  output hnp_pkg::cell_word_t          word
);
  import hnp_pkg::*;

  localparam int E    = ELEV_BITS;
  localparam int MW   = ELEV_BITS + CFG_W;
  localparam int SH_W = $clog2(MW + 1);
  localparam int SQ_W = 2 * RED_BITS;
  localparam logic [K_W-1:0] XY_FS = K_W'(XY_FULL_SCALE);
  localparam logic [K_W-1:0] Z_FS  = K_W'(Z_FULL_SCALE);

  // Stage 1: pick differences
  logic [1:0] rp, cp;
  logic signed [E:0] c_x, l_x, r_x, u_x, d_x, dz1, dz2, ndz1, ndz2;
  logic s1_vld, s1_nx, s1_ny;
  logic [E-1:0] s1_m1, s1_m2;

  always_comb begin
    rp  = (row_place == PLACE_ALT) ? PLACE_MID : row_place;
    cp  = (col_place == PLACE_ALT) ? PLACE_MID : col_place;
    c_x = {elev_center[E-1], elev_center};
    l_x = {elev_left[E-1], elev_left};
    r_x = {elev_right[E-1], elev_right};
    u_x = {elev_up[E-1], elev_up};
    d_x = {elev_down[E-1], elev_down};
    if (rp == PLACE_MID && cp == PLACE_MID) begin
      dz1 = r_x - l_x;
    end else if (cp == PLACE_LAST) begin
      dz1 = c_x - l_x;
    end else begin
      dz1 = r_x - c_x;
    end
    if (rp == PLACE_FIRST) begin
      dz2 = d_x - c_x;
    end else if (rp == PLACE_LAST) begin
      dz2 = c_x - u_x;
    end else if (cp == PLACE_FIRST) begin
      dz2 = d_x - c_x;
    end else begin
      dz2 = d_x - u_x;
    end
    ndz1 = -dz1;
    ndz2 = -dz2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= take;
    end
  end

  always_ff @(posedge clk) begin
    s1_nx <= (dz1 > 0);
    s1_ny <= dz2[E];
    s1_m1 <= dz1[E] ? ndz1[E-1:0] : dz1[E-1:0];
    s1_m2 <= dz2[E] ? ndz2[E-1:0] : dz2[E-1:0];
  end

  // Stage 2: scale magnitudes
  logic s2_vld, s2_nx, s2_ny;
  logic [MW-1:0] s2_ax, s2_ay, s2_az;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    s2_nx <= s1_nx;
    s2_ny <= s1_ny;
    s2_ax <= MW'(s1_m1) * MW'(dy_scale);
    s2_ay <= MW'(s1_m2) * MW'(dx_scale);
    s2_az <= MW'(cell_area);
  end

  // Stage 3: find the common reduction shift
  logic [MW-1:0] big;
  logic [SH_W-1:0] blen, sh;
  logic s3_vld, s3_nx, s3_ny, s3_zero;
  logic [SH_W-1:0] s3_sh;
  logic [MW-1:0] s3_ax, s3_ay, s3_az;

  always_comb begin
    big  = s2_ax | s2_ay | s2_az;
    blen = '0;
    for (int i = 0; i < MW; i++) begin
      if (big[i]) begin
        blen = SH_W'(i + 1);
      end
    end
    sh = (blen > SH_W'(RED_BITS)) ? blen - SH_W'(RED_BITS) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else begin
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    s3_nx   <= s2_nx;
    s3_ny   <= s2_ny;
    s3_zero <= (big == '0);
    s3_sh   <= sh;
    s3_ax   <= s2_ax;
    s3_ay   <= s2_ay;
    s3_az   <= s2_az;
  end

  // Stage 4: reduce the vector
  logic s4_vld, s4_nx, s4_ny, s4_zero;
  logic [RED_BITS-1:0] s4_ax, s4_ay, s4_az;
  logic [MW-1:0] shx, shy, shz;

  assign shx = s3_ax >> s3_sh;
  assign shy = s3_ay >> s3_sh;
  assign shz = s3_az >> s3_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else begin
      s4_vld <= s3_vld;
    end
  end

  always_ff @(posedge clk) begin
    s4_nx   <= s3_nx;
    s4_ny   <= s3_ny;
    s4_zero <= s3_zero;
    s4_ax   <= shx[RED_BITS-1:0];
    s4_ay   <= shy[RED_BITS-1:0];
    s4_az   <= shz[RED_BITS-1:0];
  end

  // Stage 5: squares and full-scale products
  logic s5_vld, s5_nx, s5_ny, s5_zero;
  logic [SQ_W-1:0] s5_qx, s5_qy, s5_qz;
  logic [T_W-1:0]  s5_tx, s5_ty, s5_tz;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_vld <= 1'b0;
    end else begin
      s5_vld <= s4_vld;
    end
  end

  always_ff @(posedge clk) begin
    s5_nx   <= s4_nx;
    s5_ny   <= s4_ny;
    s5_zero <= s4_zero;
    s5_qx   <= SQ_W'(s4_ax) * SQ_W'(s4_ax);
    s5_qy   <= SQ_W'(s4_ay) * SQ_W'(s4_ay);
    s5_qz   <= SQ_W'(s4_az) * SQ_W'(s4_az);
    s5_tx   <= T_W'(s4_ax) * T_W'(XY_FS);
    s5_ty   <= T_W'(s4_ay) * T_W'(XY_FS);
    s5_tz   <= T_W'(s4_az) * T_W'(Z_FS);
  end

  // Stage 6: squared length and squared targets, seed the search
  always_ff @(posedge clk) begin
    if (rst) begin
      word.vld <= 1'b0;
    end else begin
      word.vld <= s5_vld;
    end
  end

  always_ff @(posedge clk) begin
    word.zero <= s5_zero;
    word.nx   <= s5_nx;
    word.ny   <= s5_ny;
    word.s    <= S_W'(s5_qx) + S_W'(s5_qy) + S_W'(s5_qz);
    word.x    <= '{k: '0, p: '0, q: '0, f: F_W'(s5_tx) * F_W'(s5_tx)};
    word.y    <= '{k: '0, p: '0, q: '0, f: F_W'(s5_ty) * F_W'(s5_ty)};
    word.z    <= '{k: '0, p: '0, q: '0, f: F_W'(s5_tz) * F_W'(s5_tz)};
  end

endmodule
`default_nettype wire

// ===== src/hnp_cell.sv =====
// One search cell: settles one bit of each lane's code and passes the word on.
`default_nettype none
module hnp_cell #(
  parameter int BIT = 0
) (
  input  wire                 clk,
  input  wire                 rst,
  input  hnp_pkg::cell_word_t wi,
  output hnp_pkg::cell_word_t wo
);
  import hnp_pkg::*;

  localparam logic [K_W-1:0] BIT_MASK = K_W'(1) << BIT;

  // Try setting this bit: (k+2^b)^2*s = k^2*s + 2^(b+1)*k*s + 2^(2b)*s
  function automatic lane_t lane_step(input lane_t l, input logic [S_W-1:0] s);
    logic [P_W-1:0] pt;
    lane_t r;
    pt = l.p + (P_W'(l.q) << (BIT + 1)) + (P_W'(s) << (2 * BIT));
    r  = l;
    if (P_W'(pt) <= P_W'(l.f)) begin
      r.k = l.k | BIT_MASK;
      r.p = pt;
      r.q = l.q + (Q_W'(s) << BIT);
    end
    return r;
  endfunction

  // Advance the valid mark
  always_ff @(posedge clk) begin
    if (rst) begin
      wo.vld <= 1'b0;
    end else begin
      wo.vld <= wi.vld;
    end
  end

  // Advance the lanes
  always_ff @(posedge clk) begin
    wo.zero <= wi.zero;
    wo.nx   <= wi.nx;
    wo.ny   <= wi.ny;
    wo.s    <= wi.s;
    wo.x    <= lane_step(wi.x, wi.s);
    wo.y    <= lane_step(wi.y, wi.s);
    wo.z    <= lane_step(wi.z, wi.s);
  end

endmodule
`default_nettype wire

// ===== src/heightfield_normal_pack_core.sv =====
// Top level of the heightfield normal packer: registers, cell row and packing.
//
// Usage: pulse start with the five elevations and the two place codes; the
// word is taken at that edge whenever busy is low, and busy is always low,
// so a new word can be started in every cycle. Results leave in order on
// packed_normal, marked by done for exactly one cycle; the receiver cannot
// hold them off and needs none to.
// Throughput is one word per cycle. Six front stages form the
// differences, scale and reduce the vector and build the search targets;
// a row of ten cells then settles the ten code bits, one bit per cell for
// all three components at once; a last register packs the result.
// Scales are written through cfg_we/cfg_addr/cfg_wdata, index 0 dy_scale,
// 1 dx_scale, 2 cell_area; other indexes are ignored. Write them only while
// no word is in flight.
// Reset clears all in-flight words and sets every scale to 1.0 (Q16.16).
`default_nettype none
module heightfield_normal_pack_core #(
  parameter int XY_FULL_SCALE = hnp_pkg::XY_FULL_SCALE_DEF,
  parameter int Z_FULL_SCALE  = hnp_pkg::Z_FULL_SCALE_DEF,
  parameter int ELEV_BITS     = hnp_pkg::ELEV_BITS_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cfg_we,
  input  wire  [hnp_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire  [hnp_pkg::CFG_W-1:0]          cfg_wdata,
  input  wire                                start,
  output logic                               busy,
  input  wire  signed [ELEV_BITS-1:0]        elev_center,
  input  wire  signed [ELEV_BITS-1:0]        elev_left,
  input  wire  signed [ELEV_BITS-1:0]        elev_right,
  input  wire  signed [ELEV_BITS-1:0]        elev_up,
  input  wire  signed [ELEV_BITS-1:0]        elev_down,
  input  wire  [1:0]                         row_place,
  input  wire  [1:0]                         col_place,
  output logic                               done,
  output logic [hnp_pkg::OUT_W-1:0]          packed_normal
);
  import hnp_pkg::*;

  localparam logic [XY_W-1:0] XY_FS = XY_W'(XY_FULL_SCALE);

  // Scale registers
  logic [CFG_W-1:0] dy_scale, dx_scale, cell_area;

  always_ff @(posedge clk) begin
    if (rst) begin
      dy_scale  <= SCALE_ONE;
      dx_scale  <= SCALE_ONE;
      cell_area <= SCALE_ONE;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_DY_SCALE:  dy_scale  <= cfg_wdata;
        REG_DX_SCALE:  dx_scale  <= cfg_wdata;
        REG_CELL_AREA: cell_area <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Front stages
  cell_word_t w [0:K_W];

  hnp_front #(
    .XY_FULL_SCALE(XY_FULL_SCALE),
    .Z_FULL_SCALE (Z_FULL_SCALE),
    .ELEV_BITS    (ELEV_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .take       (start && !busy),
    .elev_center(elev_center),
    .elev_left  (elev_left),
    .elev_right (elev_right),
    .elev_up    (elev_up),
    .elev_down  (elev_down),
    .row_place  (row_place),
    .col_place  (col_place),
    .dy_scale   (dy_scale),
    .dx_scale   (dx_scale),
    .cell_area  (cell_area),
    .word       (w[0])
  );

  // Cell row, top bit first
  for (genvar g = 0; g < K_W; g++) begin : g_cell
    hnp_cell #(.BIT(K_W - 1 - g)) u_cell (
      .clk(clk),
      .rst(rst),
      .wi (w[g]),
      .wo (w[g+1])
    );
  end

  // Turn the floors into field codes; a negative component takes the ceiling
  cell_word_t wl;
  logic [XY_W-1:0] cx, cy, px, py;
  logic [Z_W-1:0]  pz;

  assign wl = w[K_W];

  always_comb begin
    cx = (wl.x.p == P_W'(wl.x.f)) ? XY_W'(wl.x.k) : XY_W'(wl.x.k) + XY_W'(1);
    cy = (wl.y.p == P_W'(wl.y.f)) ? XY_W'(wl.y.k) : XY_W'(wl.y.k) + XY_W'(1);
    px = wl.nx ? XY_FS - cx : XY_FS + XY_W'(wl.x.k);
    py = wl.ny ? XY_FS - cy : XY_FS + XY_W'(wl.y.k);
    pz = wl.z.k;
    if (wl.zero) begin
      px = XY_FS;
      py = XY_FS;
      pz = '0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= wl.vld;
    end
  end

  always_ff @(posedge clk) begin
    packed_normal <= {px, py, pz};
  end

endmodule
`default_nettype wire

// ===== src/hnp_chk.sv =====
// Port-level checker for the heightfield normal packer, bound to the top level.
`default_nettype none
module hnp_chk #(
  parameter int XY_FULL_SCALE = hnp_pkg::XY_FULL_SCALE_DEF,
  parameter int ELEV_BITS     = hnp_pkg::ELEV_BITS_DEF
) (
  input wire                          clk,
  input wire                          rst,
  input wire                          start,
  input wire                          busy,
  input wire signed [ELEV_BITS-1:0]   elev_center,
  input wire signed [ELEV_BITS-1:0]   elev_left,
  input wire signed [ELEV_BITS-1:0]   elev_right,
  input wire signed [ELEV_BITS-1:0]   elev_up,
  input wire signed [ELEV_BITS-1:0]   elev_down,
  input wire                          done,
  input wire [hnp_pkg::OUT_W-1:0]     packed_normal
);
  import hnp_pkg::*;

  localparam logic [XY_W-1:0] XY_FS  = XY_W'(XY_FULL_SCALE);
  localparam logic [XY_W-1:0] XY_MAX = XY_W'(2 * XY_FULL_SCALE);

  // Every accepted word comes out after the fixed latency
  a_out_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted word produced no result");

  // No result without an accepted word
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without accepted word");

  // A flat neighborhood gives a vertical normal
  a_flat: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && elev_center == elev_left && elev_center == elev_right &&
     elev_center == elev_up && elev_center == elev_down)
    |-> ##LATENCY (packed_normal[OUT_W-1:OUT_W-XY_W] == XY_FS &&
                   packed_normal[OUT_W-XY_W-1:Z_W] == XY_FS))
    else $error("flat point gave tilted normal");

  // Offset codes stay within twice the full scale
  a_x_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (packed_normal[OUT_W-1:OUT_W-XY_W] <= XY_MAX &&
              packed_normal[OUT_W-XY_W-1:Z_W] <= XY_MAX))
    else $error("offset code out of range");

endmodule

bind heightfield_normal_pack_core hnp_chk #(
  .XY_FULL_SCALE(XY_FULL_SCALE),
  .ELEV_BITS    (ELEV_BITS)
) u_hnp_chk (.*);
`default_nettype wire

// ===== sim/heightfield_normal_pack_checker.sv =====
// Checker for the heightfield normal packer: predicts packed normals and compares.
`timescale 1ns / 100ps
`default_nettype none
module heightfield_normal_pack_checker (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_we,
  input  wire  [hnp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire  [hnp_pkg::CFG_W-1:0]        cfg_wdata,
  input  wire                              start,
  input  wire                              busy,
  input  wire  signed [15:0]               elev_center,
  input  wire  signed [15:0]               elev_left,
  input  wire  signed [15:0]               elev_right,
  input  wire  signed [15:0]               elev_up,
  input  wire  signed [15:0]               elev_down,
  input  wire  [1:0]                       row_place,
  input  wire  [1:0]                       col_place,
  input  wire                              done,
  input  wire  [31:0]                      packed_normal,
  output int                               fail_count,
  output int                               pending_normals,
  output int                               normals_seen
);
  import hnp_pkg::*;

  localparam longint unsigned XY_FS = 1023;
  localparam longint unsigned Z_FS  = 1023;

  logic [31:0] dy_scale_q, dx_scale_q, cell_area_q;
  logic [31:0] normal_queue[$];

  // Does m * len <= fs * v hold, with len = sqrt(s)?
  function automatic bit code_fits(int m, longint unsigned vmag, bit vneg,
                                   longint unsigned s, longint unsigned fs);
    longint unsigned am, lhs, rhs;
    am = (m < 0) ? longint'(-m) : longint'(m);
    lhs = am * am * s;
    rhs = fs * fs * vmag * vmag;
    if (m > 0) begin
      if (vneg || vmag == 0) return 1'b0;
      return lhs <= rhs;
    end
    if (!vneg || vmag == 0) return 1'b1;
    return lhs >= rhs;
  endfunction

  function automatic logic [10:0] offset_code(longint unsigned vmag, bit vneg,
                                              longint unsigned s);
    int m;
    for (m = 1023; m > -1023; m--)
      if (code_fits(m, vmag, vneg, s, XY_FS)) break;
    return 11'(m + 1023);
  endfunction

  function automatic logic [9:0] height_code(longint unsigned vmag, longint unsigned s);
    int k;
    for (k = 1023; k > 0; k--)
      if (code_fits(k, vmag, 1'b0, s, Z_FS)) break;
    return 10'(k);
  endfunction

  function automatic logic [31:0] surface_normal_code(
      logic signed [15:0] c, logic signed [15:0] l, logic signed [15:0] r,
      logic signed [15:0] u, logic signed [15:0] d, logic [1:0] rp_in, logic [1:0] cp_in);
    logic [1:0] rp, cp;
    longint dz1, dz2;
    longint unsigned ax, ay, az, big, s;
    bit nx, ny;
    logic [10:0] px, py;
    logic [9:0] pz;
    int sh;
    rp = (rp_in == PLACE_ALT) ? PLACE_MID : rp_in;
    cp = (cp_in == PLACE_ALT) ? PLACE_MID : cp_in;
    // along-row difference
    if (rp == PLACE_MID && cp == PLACE_MID) dz1 = longint'(r) - longint'(l);
    else if (cp == PLACE_LAST)              dz1 = longint'(c) - longint'(l);
    else                                    dz1 = longint'(r) - longint'(c);
    // down-row difference
    if (rp == PLACE_FIRST)      dz2 = longint'(d) - longint'(c);
    else if (rp == PLACE_LAST)  dz2 = longint'(c) - longint'(u);
    else if (cp == PLACE_FIRST) dz2 = longint'(d) - longint'(c);
    else                        dz2 = longint'(d) - longint'(u);
    ax = longint'(dz1 < 0 ? -dz1 : dz1) * longint'({32'd0, dy_scale_q});
    ay = longint'(dz2 < 0 ? -dz2 : dz2) * longint'({32'd0, dx_scale_q});
    az = {32'd0, cell_area_q};
    nx = dz1 > 0;
    ny = dz2 < 0;
    big = ax;
    if (ay > big) big = ay;
    if (az > big) big = az;
    if (big == 0) begin
      px = 11'd1023;
      py = 11'd1023;
      pz = 10'd0;
    end else begin
      // reduce all three by a common shift until they fit 20 bits
      sh = 0;
      while ((big >> sh) >= (64'd1 << RED_BITS)) sh++;
      ax = ax >> sh;
      ay = ay >> sh;
      az = az >> sh;
      s = ax * ax + ay * ay + az * az;
      px = offset_code(ax, nx, s);
      py = offset_code(ay, ny, s);
      pz = height_code(az, s);
    end
    return {px, py, pz};
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: packed normal %s: got %08h, want %08h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      dy_scale_q  <= SCALE_ONE;
      dx_scale_q  <= SCALE_ONE;
      cell_area_q <= SCALE_ONE;
      normal_queue.delete();
    end else begin
      // compare the outgoing word with the oldest expectation
      if (done) begin
        normals_seen++;
        if (normal_queue.size() == 0)
          report_mismatch("with nothing expected", packed_normal, 32'd0);
        else begin
          logic [31:0] want;
          want = normal_queue.pop_front();
          if (packed_normal[31:21] != want[31:21])
            report_mismatch("x field", packed_normal, want);
          if (packed_normal[20:10] != want[20:10])
            report_mismatch("y field", packed_normal, want);
          if (packed_normal[9:0] != want[9:0])
            report_mismatch("z field", packed_normal, want);
        end
      end
      // predict each accepted word
      if (start && !busy)
        normal_queue.push_back(surface_normal_code(elev_center, elev_left, elev_right,
                                                   elev_up, elev_down, row_place,
                                                   col_place));
      // track register writes
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_DY_SCALE:  dy_scale_q  <= cfg_wdata;
          REG_DX_SCALE:  dx_scale_q  <= cfg_wdata;
          REG_CELL_AREA: cell_area_q <= cfg_wdata;
          default: ;
        endcase
      end
    end
    // publish how many words are still expected
    pending_normals = normal_queue.size();
  end

  initial begin
    fail_count = 0;
    normals_seen = 0;
    pending_normals = 0;
  end

endmodule
`default_nettype wire

// ===== sim/heightfield_normal_pack_core_tb.sv =====
// Testbench top for the heightfield normal packer: stimulus, watchdog and verdict.
`timescale 1ns / 100ps
`default_nettype none
module heightfield_normal_pack_core_tb;
  import hnp_pkg::*;

  localparam int IDLE_LIMIT = 3000;

  logic clk, rst;
  logic cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_W-1:0] cfg_wdata;
  logic start;
  logic busy, done;
  logic signed [15:0] elev_center, elev_left, elev_right, elev_up, elev_down;
  logic [1:0] row_place, col_place;
  logic [31:0] packed_normal;
  int fail_count, pending_normals, normals_seen;
  int words_sent, cfg_phases, idle_cycles;

  heightfield_normal_pack_core DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .start(start), .busy(busy), .elev_center(elev_center), .elev_left(elev_left),
    .elev_right(elev_right), .elev_up(elev_up), .elev_down(elev_down),
    .row_place(row_place), .col_place(col_place), .done(done),
    .packed_normal(packed_normal)
  );

  heightfield_normal_pack_checker checker_i (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .start(start), .busy(busy), .elev_center(elev_center), .elev_left(elev_left),
    .elev_right(elev_right), .elev_up(elev_up), .elev_down(elev_down),
    .row_place(row_place), .col_place(col_place), .done(done),
    .packed_normal(packed_normal), .fail_count(fail_count),
    .pending_normals(pending_normals), .normals_seen(normals_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Hold start for one word, then drop it for a random gap, which may be zero
  task automatic send_word(logic [15:0] c, logic [15:0] l, logic [15:0] r,
                           logic [15:0] u, logic [15:0] d, logic [1:0] rp, logic [1:0] cp);
    int roll, gap;
    start <= 1'b1;
    elev_center <= c;
    elev_left <= l;
    elev_right <= r;
    elev_up <= u;
    elev_down <= d;
    row_place <= rp;
    col_place <= cp;
    do @(posedge clk); while (busy);
    words_sent++;
    roll = $urandom_range(0, 99);
    if (roll < 65) gap = 0;
    else if (roll < 93) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Mostly terrain-like neighborhoods, some fully random words
  task automatic send_random_word();
    logic [15:0] base;
    logic [1:0] rp, cp;
    int spread;
    rp = 2'($urandom_range(0, 3));
    cp = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 2) == 0)
      send_word(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), rp, cp);
    else begin
      base = 16'($urandom);
      spread = ($urandom_range(0, 3) == 0) ? 4000 : 40;
      send_word(base, base + 16'($urandom_range(0, 2 * spread) - spread),
                base + 16'($urandom_range(0, 2 * spread) - spread),
                base + 16'($urandom_range(0, 2 * spread) - spread),
                base + 16'($urandom_range(0, 2 * spread) - spread), rp, cp);
    end
  endtask

  // Drain the pipeline, then write all three scales
  task automatic set_scales(logic [31:0] dy, logic [31:0] dx, logic [31:0] area);
    start <= 1'b0;
    @(posedge clk);
    while (pending_normals != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= REG_DY_SCALE;
    cfg_wdata <= dy;
    @(posedge clk);
    cfg_addr <= REG_DX_SCALE;
    cfg_wdata <= dx;
    @(posedge clk);
    cfg_addr <= REG_CELL_AREA;
    cfg_wdata <= area;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_phases++;
  endtask

  task automatic send_place_sweep();
    for (int rp = 0; rp < 4; rp++)
      for (int cp = 0; cp < 4; cp++)
        send_word(16'sd100, -16'sd50, 16'sd300, 16'sd7, -16'sd900, 2'(rp), 2'(cp));
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    start = 1'b0;
    {elev_center, elev_left, elev_right, elev_up, elev_down} = '0;
    row_place = PLACE_FIRST;
    col_place = PLACE_FIRST;
    words_sent = 0;
    cfg_phases = 0;
    idle_cycles = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: every place combination, flat ground, elevation extremes
    send_place_sweep();
    send_word(16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5, PLACE_MID, PLACE_MID);
    send_word(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, PLACE_MID, PLACE_MID);
    send_word(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, PLACE_FIRST, PLACE_LAST);
    send_word(16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'h8000, PLACE_LAST, PLACE_FIRST);
    send_word(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, PLACE_ALT, PLACE_ALT);
    repeat (140) send_random_word();

    // largest scales
    set_scales(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, PLACE_MID, PLACE_MID);
    repeat (70) send_random_word();

    // zero area and dy scale: flat ground gives a zero vector, slopes lie flat
    set_scales(32'd0, SCALE_ONE, 32'd0);
    send_word(16'sd9, 16'sd9, 16'sd9, 16'sd9, 16'sd9, PLACE_MID, PLACE_MID);
    send_place_sweep();
    repeat (50) send_random_word();

    // all zero
    set_scales(32'd0, 32'd0, 32'd0);
    repeat (20) send_random_word();

    // tiny scales
    set_scales(32'd1, 32'd1, 32'd1);
    repeat (50) send_random_word();

    // random settings
    repeat (4) begin
      set_scales($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0004_0000),
                 $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0004_0000),
                 $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0004_0000));
      repeat (55) send_random_word();
    end

    // drain and settle
    start <= 1'b0;
    @(posedge clk);
    while (pending_normals != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);

    $display("Run covered %0d words over %0d scale settings plus reset values.",
             words_sent, cfg_phases);
    $display("%0d packed normals compared, %0d field mismatches.", normals_seen, fail_count);
    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
`default_nettype wire
